// ===== hw/rtl/brp_pkg.sv =====
// Package for the bit-sliced range predicate unit.
// Holds item and result payload types, register and operation codes, and default sizes.
// No dependencies.
package brp_pkg;

    localparam int DEF_MAX_SLICES    = 32;
    localparam int DEF_ROWS_PER_WORD = 64;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 38;
    localparam int VALUE_W = 32;
    localparam int SLICE_W = 6;
    localparam int OP_W    = 3;

    typedef enum logic [1:0] {
        REG_COMPARE_VALUE = 2'd0,
        REG_COLUMN_MAX    = 2'd1,
        REG_SLICE_COUNT   = 2'd2,
        REG_OP_MODE       = 2'd3
    } cfg_index_t;

    typedef enum logic [OP_W-1:0] {
        OP_EQ = 3'd0,
        OP_GT = 3'd1,
        OP_GE = 3'd2,
        OP_LT = 3'd3,
        OP_LE = 3'd4
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] slice_word;
        logic [WORD_W-1:0] exist_word;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  match_word;
        logic [COUNT_W-1:0] match_count;
        logic [SUM_W-1:0]   chunk_sum;
    } result_t;

endpackage

// ===== hw/rtl/bitsliced_range_predicate_unit.sv =====
// Bit-sliced range predicate unit: compares a sliced integer column against a set value.
// One module: input register, per-row accumulators and result register.
// Depends on brp_pkg.
//
// Usage:
//   The item channel (item, item_valid, item_stall) carries one bit slice of a
//   64-row chunk with its row-existence word, least significant slice first.
//   After slice_count slices the result channel (result, result_valid,
//   result_stall) presents the match mask, the count of matching existing rows
//   and the sum of the existing rows' values for that chunk.
//   Throughput is one slice item per cycle; the accumulator update, popcounts
//   and shift-add sit in one stage between the input and result registers.
//   A chunk's result enters the result register as its last slice leaves the
//   input register. While the result register holds an untaken result,
//   non-final slices keep flowing; only a final slice waits, and item_stall
//   rises once the input register holds it. Configuration (cfg_we, cfg_index,
//   cfg_data) is written while no chunk is in flight. Reset clears the greater
//   and sum accumulators, sets the equal accumulator to all ones, clears both
//   pipeline valids and loads the register defaults (compare value 0, column
//   max all ones, 32 slices, EQ).
module bitsliced_range_predicate_unit
#(
    parameter int MAX_SLICES    = brp_pkg::DEF_MAX_SLICES,
    parameter int ROWS_PER_WORD = brp_pkg::DEF_ROWS_PER_WORD
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  brp_pkg::item_t                  item,
    input  logic                            item_valid,
    output logic                            item_stall,
    output brp_pkg::result_t                result,
    output logic                            result_valid,
    input  logic                            result_stall,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [brp_pkg::VALUE_W-1:0]     cfg_data
);
    import brp_pkg::*;

    localparam logic [WORD_W-1:0] ROW_MASK = (ROWS_PER_WORD >= WORD_W) ? {WORD_W{1'b1}} :
                                             ((WORD_W'(1) << ROWS_PER_WORD) - WORD_W'(1));
    localparam logic [SLICE_W:0]  MAX_LAST = (SLICE_W+1)'(MAX_SLICES - 1);

    function automatic logic [COUNT_W-1:0] pop64(input logic [WORD_W-1:0] w);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + COUNT_W'(w[i]);
        end
        return n;
    endfunction

    logic [VALUE_W-1:0] compare_value_reg;
    logic [VALUE_W-1:0] column_max_reg;
    logic [SLICE_W-1:0] slice_count_reg;
    logic [OP_W-1:0]    op_mode_reg;

    item_t              stage_reg;
    logic               stage_valid_reg;

    logic [WORD_W-1:0]  greater_reg, greater_next;
    logic [WORD_W-1:0]  equal_reg, equal_next;
    logic [SLICE_W-1:0] slice_pos_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    result_t            result_reg, result_next;
    logic               result_valid_reg;

    logic [SLICE_W:0]   last_pos;
    logic               is_last;
    logic               advance;
    logic               emit;
    logic               vbit;
    logic [WORD_W-1:0]  gt_mask, eq_mask, match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_value_reg <= '0;
            column_max_reg    <= '1;
            slice_count_reg   <= SLICE_W'(32);
            op_mode_reg       <= OP_EQ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COMPARE_VALUE: compare_value_reg <= cfg_data;
                REG_COLUMN_MAX:    column_max_reg    <= cfg_data;
                REG_SLICE_COUNT:   slice_count_reg   <= cfg_data[SLICE_W-1:0];
                REG_OP_MODE:       op_mode_reg       <= cfg_data[OP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        priority if (slice_count_reg == '0)
            last_pos = '0;
        else if ({1'b0, slice_count_reg} > MAX_LAST)
            last_pos = MAX_LAST;
        else
            last_pos = {1'b0, slice_count_reg} - (SLICE_W+1)'(1);
    end

    assign is_last    = ({1'b0, slice_pos_reg} >= last_pos);
    assign advance    = stage_valid_reg && (!is_last || !result_valid_reg || !result_stall);
    assign emit       = advance && is_last;
    assign item_stall = stage_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (!item_stall)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            stage_reg.slice_word <= item.slice_word & ROW_MASK;
            stage_reg.exist_word <= item.exist_word & ROW_MASK;
        end
    end

    assign vbit = (slice_pos_reg < SLICE_W'(VALUE_W)) ?
                  compare_value_reg[slice_pos_reg[$clog2(VALUE_W)-1:0]] : 1'b0;

    always_comb
    begin
        if (vbit)
        begin
            greater_next = greater_reg & stage_reg.slice_word;
            equal_next   = equal_reg & stage_reg.slice_word;
        end
        else
        begin
            greater_next = greater_reg | stage_reg.slice_word;
            equal_next   = equal_reg & ~stage_reg.slice_word;
        end
        sum_next = sum_reg + (SUM_W'(pop64(stage_reg.slice_word & stage_reg.exist_word))
                              << slice_pos_reg);
    end

    always_comb
    begin
        if (compare_value_reg > column_max_reg)
        begin
            gt_mask = '0;
            eq_mask = '0;
        end
        else
        begin
            gt_mask = greater_next & ROW_MASK;
            eq_mask = equal_next & ROW_MASK;
        end
        unique case (op_mode_reg)
            OP_EQ:   match = eq_mask;
            OP_GT:   match = gt_mask;
            OP_GE:   match = gt_mask | eq_mask;
            OP_LT:   match = ~(gt_mask | eq_mask) & ROW_MASK;
            OP_LE:   match = ~gt_mask & ROW_MASK;
            default: match = '0;
        endcase
        result_next.match_word  = match;
        result_next.match_count = pop64(match & stage_reg.exist_word);
        result_next.chunk_sum   = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greater_reg   <= '0;
            equal_reg     <= '1;
            slice_pos_reg <= '0;
            sum_reg       <= '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                greater_reg   <= '0;
                equal_reg     <= '1;
                slice_pos_reg <= '0;
                sum_reg       <= '0;
            end
            else
            begin
                greater_reg   <= greater_next;
                equal_reg     <= equal_next;
                slice_pos_reg <= slice_pos_reg + SLICE_W'(1);
                sum_reg       <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slice_pos_reg} <= MAX_LAST)
        else $error("slice position beyond last slice");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result_valid)
        else $error("final slice did not produce a result");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && is_last && result_valid_reg))
        else $error("input stalled without a blocked final slice");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.match_word == '0) |-> (result.match_count == '0))
        else $error("nonzero count for empty mask");

endmodule
